### hdl/bfu_pkg.sv
// Shared types and constants of the bit field unpacker.
package bfu_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_FIELD_WIDTH = 2'd0;
	localparam logic [1:0] REG_LSB_FIRST   = 2'd1;
	localparam logic [1:0] REG_NORMALIZE   = 2'd2;

	localparam logic [3:0] FIELD_WIDTH_RESET = 4'd8;
	// Index of the eighth field of a byte, after which the byte is always finished.
	localparam logic [2:0] LAST_SLOT = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXTRACT,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [3:0] width;
		logic       lsb_first;
		logic       normalize;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] value;
		logic       last;
	} res_t;

	typedef struct packed {
		logic        start;
		logic [16:0] num;
		logic [8:0]  den;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quo;
	} div_rsp_t;

endpackage

### hdl/bfu_div.sv
// Shift and subtract divider giving an 8-bit quotient.
module bfu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bfu_pkg::div_req_t  req,
	output bfu_pkg::div_rsp_t  rsp
);

	logic       busy_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [8:0] rem_q;
	logic [7:0] low_q;
	logic [8:0] den_q;
	logic [7:0] quo_q;

	logic [9:0] trial;
	logic       qbit;
	logic [9:0] diff;

	// The caller guarantees the quotient fits in 8 bits, so the top nine
	// numerator bits are already below the divisor.
	always_comb begin
		trial = {rem_q, low_q[7]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[16:8];
			low_q <= req.num[7:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[8:0] : trial[8:0];
			low_q <= {low_q[6:0], 1'b0};
			quo_q <= {quo_q[6:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

### hdl/bfu_ctrl.sv
// Sequencer that cuts fields out of the bit accumulator one per step.
module bfu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  bfu_pkg::cfg_t      cfg,
	input  logic               width_clr,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               realign,
	output bfu_pkg::res_t      res,
	input  logic               res_ready,
	output bfu_pkg::div_req_t  div_req,
	input  bfu_pkg::div_rsp_t  div_rsp
);

	function automatic logic [3:0] eff_width(input logic [3:0] wr);
		logic [3:0] r;
		r = wr;
		if (wr == 4'd0) r = 4'd1;
		if (wr > 4'd8) r = 4'd8;
		return r;
	endfunction

	function automatic logic [7:0] width_mask(input logic [3:0] wd);
		logic [8:0] t;
		t = (9'd1 << wd) - 9'd1;
		return t[7:0];
	endfunction

	function automatic logic [6:0] low_mask(input logic [2:0] c);
		logic [7:0] t;
		t = (8'd1 << c) - 8'd1;
		return t[6:0];
	endfunction

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

	bfu_pkg::state_t state_q, state_d;
	logic [14:0] acc_q;
	logic [3:0]  avail_q;
	logic [2:0]  n_q;
	logic [6:0]  left_bits_q;
	logic [2:0]  left_cnt_q;
	logic [7:0]  val_q;

	logic [3:0]  w;
	logic [7:0]  fmask;
	logic [3:0]  rest;
	logic [14:0] shifted;
	logic [7:0]  raw;
	logic [7:0]  rev;
	logic [7:0]  fval;
	logic        is_last;
	logic [2:0]  new_cnt;
	logic [6:0]  new_bits;
	logic        emit;
	logic        adv;
	logic        fin;
	logic        accept;
	logic [6:0]  base_bits;
	logic [2:0]  base_cnt;

	// Field datapath: one shift of the accumulator selects the current field.
	always_comb begin
		w        = eff_width(cfg.width);
		fmask    = width_mask(w);
		rest     = avail_q - w;
		shifted  = acc_q >> rest;
		raw      = shifted[7:0] & fmask;
		rev      = reverse8(raw) >> (4'd8 - w);
		fval     = cfg.lsb_first ? rev : raw;
		is_last  = (rest < w) || (n_q == bfu_pkg::LAST_SLOT);
		new_cnt  = (rest > 4'd7) ? 3'd7 : rest[2:0];
		new_bits = acc_q[6:0] & low_mask(new_cnt);
	end

	always_comb begin
		emit   = ((state_q == bfu_pkg::ST_EXTRACT) && !cfg.normalize) ||
		         (state_q == bfu_pkg::ST_EMIT);
		adv    = emit && res_ready;
		fin    = adv && is_last;
		accept = in_valid && in_ready;
		if (realign) begin
			base_bits = 7'd0;
			base_cnt  = 3'd0;
		end else if (fin) begin
			base_bits = new_bits;
			base_cnt  = new_cnt;
		end else begin
			base_bits = left_bits_q;
			base_cnt  = left_cnt_q;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bfu_pkg::ST_IDLE: begin
				if (in_valid) state_d = bfu_pkg::ST_EXTRACT;
			end
			bfu_pkg::ST_EXTRACT: begin
				if (cfg.normalize) begin
					state_d = bfu_pkg::ST_DIVIDE;
				end else if (fin && !in_valid) begin
					state_d = bfu_pkg::ST_IDLE;
				end
			end
			bfu_pkg::ST_DIVIDE: begin
				if (div_rsp.done) state_d = bfu_pkg::ST_EMIT;
			end
			bfu_pkg::ST_EMIT: begin
				if (fin && !in_valid) begin
					state_d = bfu_pkg::ST_IDLE;
				end else if (adv) begin
					state_d = bfu_pkg::ST_EXTRACT;
				end
			end
			default: state_d = bfu_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready      = (state_q == bfu_pkg::ST_IDLE) || fin;
		res.valid     = emit;
		res.value     = (state_q == bfu_pkg::ST_EMIT) ? val_q : fval;
		res.last      = is_last;
		div_req.start = (state_q == bfu_pkg::ST_EXTRACT) && cfg.normalize;
		div_req.num   = {fval, 9'd0} - {8'd0, fval, 1'b0} + {9'd0, fmask};
		div_req.den   = {fmask, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfu_pkg::ST_IDLE;
			left_bits_q <= 7'd0;
			left_cnt_q  <= 3'd0;
		end else begin
			state_q <= state_d;
			if (width_clr) begin
				left_bits_q <= 7'd0;
				left_cnt_q  <= 3'd0;
			end else if (fin) begin
				left_bits_q <= new_bits;
				left_cnt_q  <= new_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q   <= {base_bits, data_byte};
			avail_q <= {1'b1, base_cnt};
			n_q     <= 3'd0;
		end else if (adv) begin
			avail_q <= rest;
			n_q     <= n_q + 3'd1;
		end
		if ((state_q == bfu_pkg::ST_DIVIDE) && div_rsp.done) begin
			val_q <= div_rsp.quo;
		end
	end

endmodule

### hdl/bit_field_unpacker.sv
// Top level of the bit field unpacker: configuration, output register, sequencer and divider.
// Raw fields leave at one per cycle while the output register can take them, and the
// next byte is taken in the cycle its last field leaves.
// With normalize set each field goes through the eight-step divider. Results reach
// the ports through the output register.
// Reset clears the leftover bits, the sequencer, the output valid flag, lsb_first and normalize and loads width 8.
module bit_field_unpacker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       realign,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] field_value,
	output logic       last
);

	bfu_pkg::cfg_t     cfg_q;
	logic              width_clr;
	bfu_pkg::res_t     res;
	logic              res_ready;
	bfu_pkg::div_req_t div_req;
	bfu_pkg::div_rsp_t div_rsp;

	logic       out_valid_q;
	logic [7:0] out_value_q;
	logic       out_last_q;

	// Configuration writes always complete; the user must keep them to idle (unchecked).
	assign cfg_ready = 1'b1;
	// A write of the field width throws away the leftover bits; a byte never yields more
	// than eight fields in any case.
	assign width_clr = cfg_valid && (cfg_index == bfu_pkg::REG_FIELD_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width     <= bfu_pkg::FIELD_WIDTH_RESET;
			cfg_q.lsb_first <= 1'b0;
			cfg_q.normalize <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bfu_pkg::REG_FIELD_WIDTH: cfg_q.width     <= cfg_data;
				bfu_pkg::REG_LSB_FIRST:   cfg_q.lsb_first <= cfg_data[0];
				bfu_pkg::REG_NORMALIZE:   cfg_q.normalize <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The output register frees the sequencer from the consumer: a new result may
	// load whenever the register is empty or is being emptied in this cycle.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			out_value_q <= res.value;
			out_last_q  <= res.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign field_value = out_value_q;
	assign last        = out_last_q;

	bfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.width_clr (width_clr),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.realign   (realign),
		.res       (res),
		.res_ready (res_ready),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

	// Rounded scaling to 0..255 is floor((510*v + d) / (2*d)) with d = 2^w - 1.
	bfu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule
